// ===== hdl/bedsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bedsd_pkg
// Shared widths, codes and types of the block exponent delta sample decoder.
// ----------------------------------------------------------------------------
package bedsd_pkg;

    localparam int BANK_ADDR_BITS_DEF = 20;

    localparam int OPCODE_W  = 2;
    localparam int ADDRESS_W = 24;
    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 24;
    localparam int WHERE_W   = 20;
    localparam int STATUS_W  = 2;
    localparam int SUM_W     = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_READ    = 2'd2,
        OP_BAD     = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BADOP = 2'd2
    } t_status;

    // payload carried along the decode pipeline
    typedef struct packed {
        logic               rd;     // successful read
        logic               rst;    // successful restart
        logic               bit4;   // exponent nibble select
        t_status            status;
        logic [WHERE_W-1:0] where;
    } t_stage;

endpackage
`default_nettype wire

// ===== hdl/bedsd_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bedsd channel interfaces
// Valid/ready channels for command words in and sample words out.
// ----------------------------------------------------------------------------
interface bedsd_in_if;
    import bedsd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [ADDRESS_W-1:0] address;
    logic [BYTE_W-1:0]    data_byte;

    modport source (output valid, output opcode, output address, output data_byte,
                    input ready);
    modport sink   (input valid, input opcode, input address, input data_byte,
                    output ready);
endinterface

interface bedsd_out_if;
    import bedsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [WHERE_W-1:0]         sample_address;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output sample, output sample_address, output status,
                    input ready);
    modport sink   (input valid, input sample, input sample_address, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/bedsd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bedsd_ram
// Generic single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bedsd_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 8
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire                  i_we,
    input  wire  [ADDR_BITS-1:0] i_addr,
    input  wire  [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0] o_rdata
);
    logic [DATA_BITS-1:0] r_mem [(2**ADDR_BITS)];

    // read data holds when the port is idle or writing
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/block_exponent_delta_sample_decoder.sv =====
`default_nettype none
// Pipeline: an accepted command word moves through stages 1, 2 and 3 into the
//   output register; the whole pipeline holds while o_out.ready holds it off.
// Throughput: load, restart and invalid words one per cycle unless o_out.ready stalls;
//   a read word blocks input while delta then exponent byte use the single bank port.
// Reset: synchronous, active low; clears read pointer, running sum and pipeline
//   valids. The bank itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// block_exponent_delta_sample_decoder
// Block floating point DPCM decoder with an internal byte-wide wave bank.
// ----------------------------------------------------------------------------
module block_exponent_delta_sample_decoder #(
    parameter int BANK_ADDR_BITS = bedsd_pkg::BANK_ADDR_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bedsd_in_if.sink     i_in,
    bedsd_out_if.source  o_out
);
    import bedsd_pkg::*;

    localparam int ABITS = BANK_ADDR_BITS;

    typedef enum logic {S_ISSUE, S_EXP} t_state;

    // control
    t_state             r_state;
    logic [ABITS:0]     r_ptr;       // one extra bit: stops at bank size
    logic [SUM_W-1:0]   r_sum;
    logic               r_p1_v, r_p2_v, r_p3_v, r_out_v;

    // payload
    t_stage             r_p1, r_p2, r_p3;
    logic [ABITS-1:0]   r_exp_addr;
    logic [BYTE_W-1:0]  r_delta;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [WHERE_W-1:0] r_out_where;
    t_status            r_out_status;

    // bank port
    logic               ram_en, ram_we;
    logic [ABITS-1:0]   ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               adv, in_fire, addr_oor, ptr_oor;
    t_opcode            op;
    logic [ABITS-1:0]   cur_ptr;
    logic [ADDRESS_W-1:0] ptr_wide;
    t_stage             n_p1;
    logic [3:0]         expo;
    logic [SUM_W-1:0]   n_sum;
    logic signed [SAMPLE_W-1:0] n_sample;

    // whole pipeline moves together when the output register can take a word
    assign adv        = !r_out_v || o_out.ready;
    assign i_in.ready = adv && (r_state == S_ISSUE);
    assign in_fire    = i_in.valid && i_in.ready;

    assign op       = t_opcode'(i_in.opcode);
    assign addr_oor = (i_in.address >> ABITS) != '0;
    assign ptr_oor  = r_ptr[ABITS];
    assign cur_ptr  = r_ptr[ABITS-1:0];
    assign ptr_wide = ADDRESS_W'(cur_ptr);

    // decode of the incoming word
    always_comb begin
        n_p1        = '0;
        n_p1.status = ST_OK;
        n_p1.bit4   = cur_ptr[4];
        unique case (op)
            OP_LOAD: begin
                if (addr_oor) n_p1.status = ST_RANGE;
            end
            OP_RESTART: begin
                if (addr_oor) n_p1.status = ST_RANGE;
                else          n_p1.rst    = 1'b1;
            end
            OP_READ: begin
                if (ptr_oor) begin
                    n_p1.status = ST_RANGE;
                end else begin
                    n_p1.rd    = 1'b1;
                    n_p1.where = ptr_wide[WHERE_W-1:0];
                end
            end
            OP_BAD: begin
                n_p1.status = ST_BADOP;
            end
            default: n_p1.status = ST_BADOP;
        endcase
    end

    // bank port: load write or delta read on accept, exponent read in the S_EXP state after it
    always_comb begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = cur_ptr;
        if (in_fire) begin
            if (op == OP_LOAD && !addr_oor) begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = i_in.address[ABITS-1:0];
            end else if (op == OP_READ && !ptr_oor) begin
                ram_en   = 1'b1;
            end
        end else if (adv && r_state == S_EXP) begin
            ram_en   = 1'b1;
            ram_addr = r_exp_addr;
        end
    end

    bedsd_ram #(
        .ADDR_BITS (ABITS),
        .DATA_BITS (BYTE_W)
    ) u_bank (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.data_byte),
        .o_rdata (ram_rdata)
    );

    // accumulate: stage 2 sees the exponent byte on the bank read data
    assign expo  = r_p2.bit4 ? ram_rdata[7:4] : ram_rdata[3:0];
    assign n_sum = r_sum + ({{(SUM_W-BYTE_W){r_delta[BYTE_W-1]}}, r_delta} << expo);

    // saturate sum*128 to signed 24 bits
    always_comb begin
        if (!r_sum[SUM_W-1] && (|r_sum[SUM_W-2:16])) begin
            n_sample = SAMPLE_W'(24'sh7fffff);
        end else if (r_sum[SUM_W-1] && !(&r_sum[SUM_W-2:16])) begin
            n_sample = SAMPLE_W'(24'sh800000);
        end else begin
            n_sample = {r_sum[16:0], 7'b0};
        end
    end

    // control state and valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ISSUE;
            r_ptr   <= '0;
            r_sum   <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_p1_v  <= in_fire;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_out_v <= r_p3_v;
            unique case (r_state)
                S_ISSUE: begin
                    if (in_fire && n_p1.rd) begin
                        r_ptr   <= r_ptr + (ABITS+1)'(1);
                        r_state <= S_EXP;
                    end else if (in_fire && n_p1.rst) begin
                        r_ptr   <= (ABITS+1)'({i_in.address[ABITS-1:4], 4'b0});
                    end
                end
                S_EXP: r_state <= S_ISSUE;
                default: r_state <= S_ISSUE;
            endcase
            if (r_p2_v && r_p2.rd) begin
                r_sum <= n_sum;
            end else if (r_p2_v && r_p2.rst) begin
                r_sum <= '0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (in_fire) begin
                r_exp_addr <= ABITS'(cur_ptr >> 5);
            end
            r_p1    <= n_p1;
            r_p2    <= r_p1;
            r_delta <= ram_rdata;   // delta byte arrives while stage 1 holds the read
            r_p3    <= r_p2;
            r_out_sample <= r_p3.rd ? n_sample : '0;
            r_out_where  <= r_p3.where;
            r_out_status <= r_p3.status;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.sample         = r_out_sample;
    assign o_out.sample_address = r_out_where;
    assign o_out.status         = r_out_status;

`ifndef NO_ASSERTIONS
    a_rd_in_p1_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_v && r_p1.rd) |-> (r_state == S_EXP))
        else $error("read in stage 1 without exponent fetch");

    a_rd_in_p2_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_v && r_p2.rd) |-> (r_state == S_ISSUE))
        else $error("exponent byte not on bank read data");

    a_no_accept_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> !i_in.ready)
        else $error("word accepted during exponent fetch");

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && op == OP_READ && !ptr_oor) |=>
            (r_ptr == $past(r_ptr) + (ABITS+1)'(1)))
        else $error("read pointer did not advance");

    a_ptr_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr[ABITS] |-> (r_ptr[ABITS-1:0] == '0))
        else $error("read pointer beyond bank size");
`endif

endmodule
`default_nettype wire
